[rtl/core/rlut_pkg.sv]
// ----------------------------------------------------------------------------
// rlut_pkg: shared types and constants of the 3D LUT color grader
// Widths of the transaction fields, the command codes passed from the front
// end to the back end, and the queue entry format.
// ----------------------------------------------------------------------------
`default_nettype none

package rlut_pkg;

  // Default grid size along each color axis.
  localparam int RLUT_GRID_POINTS = 32;
  // Fractional bits of a table entry (1 << ENTRY_FRAC_BITS means 1.0).
  localparam int ENTRY_FRAC_BITS  = 16;

  localparam int ENTRY_W    = 17;
  localparam int PIX_W      = 8;
  localparam int INDEX_W    = 15;
  // A pixel channel splits into a grid index and a 3-bit blend weight.
  localparam int FRAC_W     = 3;
  // Address field of a queue entry, wide enough for the largest grid (64^3).
  localparam int ADDR_W     = 18;
  localparam int BLEND_W    = ENTRY_W + FRAC_W;
  localparam int SCALE_W    = BLEND_W + PIX_W;
  localparam int PIX_MAX    = (1 << PIX_W) - 1;

  localparam int QUEUE_DEPTH = 4;

  // Configuration port.
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_LUT_READY = CFG_ADDR_W'(0);

  // Input command codes.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_GRADE = 1'b1;

  // What the back end does with a queued transaction.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_GRADE = 2'd1,
    OP_PASS  = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr_start;
    logic [ADDR_W-1:0] addr_end;
    logic [ENTRY_W-1:0] entry_red;
    logic [ENTRY_W-1:0] entry_green;
    logic [ENTRY_W-1:0] entry_blue;
    logic [PIX_W-1:0]  pixel_red;
    logic [PIX_W-1:0]  pixel_green;
    logic [PIX_W-1:0]  pixel_blue;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/core/rlut_if.sv]
// ----------------------------------------------------------------------------
// rlut_if: channel interfaces of the 3D LUT color grader
// Input channel carrying load and pixel transactions, and result channel
// carrying graded pixels. Both use a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlut_in_if;
  import rlut_pkg::*;

  logic               valid;
  logic               ready;
  logic               command;
  logic [INDEX_W-1:0] table_index;
  logic [ENTRY_W-1:0] entry_red;
  logic [ENTRY_W-1:0] entry_green;
  logic [ENTRY_W-1:0] entry_blue;
  logic [PIX_W-1:0]   pixel_red;
  logic [PIX_W-1:0]   pixel_green;
  logic [PIX_W-1:0]   pixel_blue;

  modport source (
    output valid, command, table_index, entry_red, entry_green, entry_blue,
           pixel_red, pixel_green, pixel_blue,
    input  ready
  );

  modport sink (
    input  valid, command, table_index, entry_red, entry_green, entry_blue,
           pixel_red, pixel_green, pixel_blue,
    output ready
  );
endinterface

interface rlut_out_if;
  import rlut_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] graded_red;
  logic [PIX_W-1:0] graded_green;
  logic [PIX_W-1:0] graded_blue;
  logic             clipped;

  modport source (
    output valid, graded_red, graded_green, graded_blue, clipped,
    input  ready
  );

  modport sink (
    input  valid, graded_red, graded_green, graded_blue, clipped,
    output ready
  );
endinterface

`default_nettype wire

[rtl/core/rlut_front.sv]
// ----------------------------------------------------------------------------
// rlut_front: front end of the 3D LUT color grader
// Accepts input transactions, drops loads beyond the table, and turns pixels
// into start and end table addresses for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rlut_front #(
  parameter int GRID_POINTS = rlut_pkg::RLUT_GRID_POINTS
) (
  rlut_in_if.sink        items,
  input  wire logic      lut_ready,
  input  wire logic      queue_full,
  output logic           push,
  output rlut_pkg::cmd_t push_cmd
);
  import rlut_pkg::*;

  localparam int TABLE_DEPTH = GRID_POINTS * GRID_POINTS * GRID_POINTS;
  localparam int AW          = $clog2(TABLE_DEPTH);
  localparam int GI_W        = $clog2(GRID_POINTS);
  localparam int GRID_LAST   = GRID_POINTS - 2;
  localparam logic [AW-1:0] STRIDE_G = AW'(GRID_POINTS);
  localparam logic [AW-1:0] STRIDE_B = AW'(GRID_POINTS * GRID_POINTS);
  localparam logic [AW-1:0] DIAG_STEP = AW'(1 + GRID_POINTS + GRID_POINTS * GRID_POINTS);

  // Grid index of one channel, clamped so that the end entry stays on the grid.
  function automatic logic [GI_W-1:0] grid_of(input logic [PIX_W-1:0] v);
    logic [PIX_W-FRAC_W-1:0] g;
    g = v[PIX_W-1:FRAC_W];
    if (32'(g) > GRID_LAST) begin
      return GI_W'(GRID_LAST);
    end
    return GI_W'(g);
  endfunction

  logic [GI_W-1:0] gi_r, gi_g, gi_b;
  logic [AW-1:0]   addr_start, addr_end;
  logic            load_in_range;
  logic            accept;

  assign items.ready = !queue_full;
  assign accept      = items.valid && !queue_full;

  always_comb begin
    gi_r       = grid_of(items.pixel_red);
    gi_g       = grid_of(items.pixel_green);
    gi_b       = grid_of(items.pixel_blue);
    addr_start = AW'(gi_r) + AW'(gi_g) * STRIDE_G + AW'(gi_b) * STRIDE_B;
    addr_end   = addr_start + DIAG_STEP;
  end

  assign load_in_range = 32'(items.table_index) < TABLE_DEPTH;

  always_comb begin
    push_cmd.entry_red   = items.entry_red;
    push_cmd.entry_green = items.entry_green;
    push_cmd.entry_blue  = items.entry_blue;
    push_cmd.pixel_red   = items.pixel_red;
    push_cmd.pixel_green = items.pixel_green;
    push_cmd.pixel_blue  = items.pixel_blue;
    if (items.command == CMD_LOAD) begin
      push_cmd.op         = OP_WRITE;
      push_cmd.addr_start = ADDR_W'(items.table_index);
      push_cmd.addr_end   = ADDR_W'(items.table_index);
    end else begin
      push_cmd.op         = lut_ready ? OP_GRADE : OP_PASS;
      push_cmd.addr_start = ADDR_W'(addr_start);
      push_cmd.addr_end   = ADDR_W'(addr_end);
    end
  end

  // A load beyond the table is consumed without reaching the queue.
  assign push = accept && !(items.command == CMD_LOAD && !load_in_range);

endmodule

`default_nettype wire

[rtl/core/rlut_queue.sv]
// ----------------------------------------------------------------------------
// rlut_queue: command queue between front end and back end
// A small first-in first-out buffer of decoded commands.
// ----------------------------------------------------------------------------
`default_nettype none

module rlut_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire rlut_pkg::cmd_t  push_cmd,
  input  wire logic            pop,
  output logic                 full,
  output logic                 empty,
  output rlut_pkg::cmd_t       head
);
  import rlut_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;

  assign full  = count == CNT_W'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - CNT_W'(1);
    end
  end

  // The depth is a power of two, so the pointers wrap on their own.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds its depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full && !pop |-> !push)
    else $error("push into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("pop from an empty queue");

endmodule

`default_nettype wire

[rtl/core/rlut_back.sv]
// ----------------------------------------------------------------------------
// rlut_back: back end of the 3D LUT color grader
// Holds the color table, reads the start and end entries of each graded pixel,
// blends along the diagonal, scales, saturates (or passes the pixel) and registers it.
// ----------------------------------------------------------------------------
`default_nettype none

module rlut_back #(
  parameter int GRID_POINTS = rlut_pkg::RLUT_GRID_POINTS
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           queue_empty,
  input  wire rlut_pkg::cmd_t head,
  output logic                pop,
  rlut_out_if.source          results
);
  import rlut_pkg::*;

  localparam int TABLE_DEPTH = GRID_POINTS * GRID_POINTS * GRID_POINTS;
  localparam int AW          = $clog2(TABLE_DEPTH);
  localparam int WORD_W      = 3 * ENTRY_W;
  localparam int SHIFT       = ENTRY_FRAC_BITS + FRAC_W;
  localparam logic [FRAC_W:0] WEIGHT_ONE = (FRAC_W + 1)'(1 << FRAC_W);

  logic [WORD_W-1:0] color_table [TABLE_DEPTH];

  logic              adv;
  logic              do_write, do_read;
  logic [WORD_W-1:0] rd_start, rd_end;

  logic             s1_valid, s1_pass;
  logic [PIX_W-1:0] s1_pix [3];
  logic             s2_valid, s2_pass;
  logic [PIX_W-1:0] s2_pix [3];
  logic [BLEND_W-1:0] s2_blend [3];

  logic [ENTRY_W-1:0] st [3];
  logic [ENTRY_W-1:0] en [3];
  logic [BLEND_W-1:0] blend [3];

  logic [PIX_W-1:0] res_pix [3];
  logic             res_clip;
  logic             res_valid;
  logic [PIX_W-1:0] out_pix [3];
  logic             out_clip;

  // The whole pipeline moves whenever the result register can take a value.
  assign adv      = !res_valid || results.ready;
  assign pop      = adv && !queue_empty;
  assign do_write = pop && head.op == OP_WRITE;
  assign do_read  = pop && head.op == OP_GRADE;

  always_ff @(posedge clk) begin
    if (do_write) begin
      color_table[head.addr_start[AW-1:0]] <=
        {head.entry_red, head.entry_green, head.entry_blue};
    end
    if (do_read) begin
      rd_start <= color_table[head.addr_start[AW-1:0]];
      rd_end   <= color_table[head.addr_end[AW-1:0]];
    end
  end

  // Stage 1: table words are available; form the weighted sum per channel.
  always_comb begin
    st[0] = rd_start[WORD_W-1 -: ENTRY_W];
    st[1] = rd_start[2*ENTRY_W-1 -: ENTRY_W];
    st[2] = rd_start[ENTRY_W-1:0];
    en[0] = rd_end[WORD_W-1 -: ENTRY_W];
    en[1] = rd_end[2*ENTRY_W-1 -: ENTRY_W];
    en[2] = rd_end[ENTRY_W-1:0];
    for (int k = 0; k < 3; k++) begin
      blend[k] = BLEND_W'(WEIGHT_ONE - (FRAC_W + 1)'(s1_pix[k][FRAC_W-1:0])) *
                 BLEND_W'(st[k]) +
                 BLEND_W'(s1_pix[k][FRAC_W-1:0]) * BLEND_W'(en[k]);
    end
  end

  // Stage 2: scale by 255, drop the fraction and saturate, or pass the pixel through.
  always_comb begin
    logic [SCALE_W-1:0] scaled;
    logic [SCALE_W-1:0] level;
    out_clip = 1'b0;
    for (int k = 0; k < 3; k++) begin
      scaled = {s2_blend[k], {PIX_W{1'b0}}} - SCALE_W'(s2_blend[k]);
      level  = scaled >> SHIFT;
      if (s2_pass) begin
        out_pix[k] = s2_pix[k];
      end else if (level > SCALE_W'(PIX_MAX)) begin
        out_pix[k] = PIX_W'(PIX_MAX);
        out_clip   = 1'b1;
      end else begin
        out_pix[k] = level[PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= pop && head.op != OP_WRITE;
      s2_valid  <= s1_valid;
      res_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pass   <= head.op == OP_PASS;
      s1_pix[0] <= head.pixel_red;
      s1_pix[1] <= head.pixel_green;
      s1_pix[2] <= head.pixel_blue;
      s2_pass   <= s1_pass;
      s2_pix    <= s1_pix;
      s2_blend  <= blend;
      res_pix   <= out_pix;
      res_clip  <= out_clip;
    end
  end

  assign results.valid        = res_valid;
  assign results.graded_red   = res_pix[0];
  assign results.graded_green = res_pix[1];
  assign results.graded_blue  = res_pix[2];
  assign results.clipped      = res_clip;

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    adv && do_write |=> !s1_valid)
    else $error("table write produced a pipeline slot");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(s1_valid) && $stable(s2_valid))
    else $error("pipeline moved while the result was stalled");

  a_clip_saturates: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_clip |-> res_pix[0] == PIX_W'(PIX_MAX) ||
      res_pix[1] == PIX_W'(PIX_MAX) || res_pix[2] == PIX_W'(PIX_MAX))
    else $error("clip flag without a saturated channel");

endmodule

`default_nettype wire

[rtl/core/rgb_3d_lut_color_grade_unit.sv]
// ----------------------------------------------------------------------------
// rgb_3d_lut_color_grade_unit: 3D lookup-table color grader
// Loads a GRID_POINTS^3 table of RGB entries and grades pixels by blending
// the two table entries at the ends of the grid cell's diagonal.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Moves
//   items     in         valid / ready         table loads and pixels
//   results   out        valid / ready         graded pixels with clip flag
//   APB       in         psel+penable+pwrite   lut_ready register at 0x0
//
// The block takes one transaction per clock while the queue has room. A pixel
// transaction reaches results through the command queue, the registered table
// read and the blend register, then the result register (the scaling and
// saturation sit in front of that register).
// Sustained rate is set by the single table write/read stage in the back end,
// which handles one command per clock while results is not stalled.
// Reset clears the queue, the pipeline valid flags and lut_ready. The color
// table is not cleared; each entry must be loaded before a pixel reads it.
// When results stalls, the back end holds, and the four-entry queue keeps
// items flowing until it fills; then items.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_3d_lut_color_grade_unit #(
  parameter int GRID_POINTS = rlut_pkg::RLUT_GRID_POINTS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  rlut_in_if.sink                              items,
  rlut_out_if.source                           results,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rlut_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [rlut_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [rlut_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready
);
  import rlut_pkg::*;

  logic lut_ready;
  logic cfg_write;

  logic push, pop;
  logic queue_full, queue_empty;
  cmd_t push_cmd, head;

  // Configuration: a single bit register. Writes complete in the access phase
  // and the port never inserts wait states.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && paddr == REG_LUT_READY;

  always_ff @(posedge clk) begin
    if (rst) begin
      lut_ready <= 1'b0;
    end else if (cfg_write) begin
      lut_ready <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_LUT_READY) begin
      prdata = CFG_DATA_W'(lut_ready);
    end
  end

  // Front end: decodes each transaction into a table write, a graded pixel
  // or a pass-through pixel, with the table addresses already worked out.
  rlut_front #(
    .GRID_POINTS (GRID_POINTS)
  ) u_front (
    .items      (items),
    .lut_ready  (lut_ready),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // Queue that lets the front end keep accepting while results is stalled.
  rlut_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (queue_full),
    .empty    (queue_empty),
    .head     (head)
  );

  // Back end: table memory, diagonal blend, scaling and result register.
  rlut_back #(
    .GRID_POINTS (GRID_POINTS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .head        (head),
    .pop         (pop),
    .results     (results)
  );

endmodule

`default_nettype wire
